@@ rtl/mss_pkg.sv @@
// Shared types and constants of the multitone sine synthesizer.
`timescale 1ns / 1ps

package mss_pkg;

	localparam int ACC_W      = 18;
	localparam int FREQ_W     = 17;
	localparam int AMP_W      = 15;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int TONE_SLOTS = 7;
	localparam int SLOT_W     = 3;
	localparam int MUL_W      = 31;
	localparam int SUM_W      = 34;
	localparam int CONTRIB_W  = 31;
	localparam int PCM_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = CFG_IDX_W'(0);
	localparam logic [ACC_W-1:0]     RATE_RESET      = ACC_W'(48000);

	localparam logic [MUL_W-1:0] C1 = 31'd1686629713;
	localparam logic [MUL_W-1:0] C3 = 31'd693598668;
	localparam logic [MUL_W-1:0] C5 = 31'd85569306;
	localparam logic [MUL_W-1:0] C7 = 31'd5026995;
	localparam logic [MUL_W-1:0] C9 = 31'd172272;

	localparam logic [AMP_W-1:0] MAG_MAX = 15'd32767;

	typedef logic [AMP_W-1:0]  amp_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [ACC_W-1:0]  acc_t;

endpackage

@@ rtl/multitone_sine_synthesizer.sv @@
// Top level of the multitone sine synthesizer.
//
//  port group   direction  handshake            payload
//  in           to block   in_valid / in_stall  restart
//  out          from block out_valid/out_stall  sample, clipped, range_error
//  cfg          to block   cfg_wen              cfg_index, cfg_data
//
// Per tone in range a sample runs a check and a read state, the serial divider
// (ACC_W + SINE_TABLE_BITS shifts) and the shared-multiplier sine sequencer (a
// multiply and a write-back per step); a tone out of range only flags a range
// error. Reset clears the phase-accumulator valid bits, so no clearing pass runs;
// a restart transaction clears the same bits. A finished sample holds the block while
// the previous one waits in the output register under out_stall.
`timescale 1ns / 1ps

module multitone_sine_synthesizer
	import mss_pkg::*;
#(
	parameter int NUM_TONES       = 7,
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [PCM_W-1:0] sample,
	output logic                    clipped,
	output logic                    range_error,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b00_0001,
		S_CHECK = 6'b00_0010,
		S_READ  = 6'b00_0100,
		S_DIV   = 6'b00_1000,
		S_SINE  = 6'b01_0000,
		S_DONE  = 6'b10_0000
	} state_t;

	state_t                   state_q;
	acc_t                     rate_q;
	logic [CFG_W-1:0]         tone_q [TONE_SLOTS];
	logic [TONE_SLOTS-1:0]    vld_q;
	logic [SLOT_W-1:0]        t_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     rerr_q;
	logic                     out_valid_q;
	logic signed [PCM_W-1:0]  sample_q;
	logic                     clipped_q;
	logic                     range_error_q;

	freq_t                       freq;
	amp_t                        amp;
	acc_t                        acc_rd;
	acc_t                        acc_cur;
	logic                        out_of_range;
	logic                        div_start;
	logic                        div_done;
	logic [SINE_TABLE_BITS-1:0]  div_idx;
	acc_t                        div_mod;
	logic [ACC_W:0]              acc_sum;
	acc_t                        acc_next;
	logic                        sine_done;
	logic signed [CONTRIB_W-1:0] sine_contrib;
	logic                        wr_en;
	logic [SLOT_W-1:0]           cfg_slot;
	logic [SUM_W-1:0]            sum_abs;
	logic [18:0]                 sum_mag;
	logic signed [PCM_W-1:0]     sat_sample;
	logic                        sat_clip;
	logic                        out_free;

	always_comb begin
		freq         = tone_q[t_q][FREQ_W-1:0];
		amp          = tone_q[t_q][CFG_W-1:FREQ_W];
		out_of_range = {1'b0, freq} >= rate_q;
		acc_cur      = vld_q[t_q] ? acc_rd : '0;
		div_start    = (state_q == S_READ);
		acc_sum      = {1'b0, div_mod} + {2'b00, freq};
		acc_next     = (acc_sum >= {1'b0, rate_q}) ? ACC_W'(acc_sum - {1'b0, rate_q})
		                                           : acc_sum[ACC_W-1:0];
		wr_en        = (state_q == S_DIV) && div_done;
		cfg_slot     = cfg_index - SLOT_W'(1);
		out_free     = !out_valid_q || !out_stall;
	end

	always_comb begin
		sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		sum_mag  = sum_abs[SUM_W-1:15];
		if (sum_q[SUM_W-1]) begin
			sat_clip   = sum_mag > 19'd32768;
			sat_sample = sat_clip ? PCM_W'(16'sh8000) : $signed(PCM_W'(0) - sum_mag[PCM_W-1:0]);
		end else begin
			sat_clip   = sum_mag > 19'd32767;
			sat_sample = sat_clip ? PCM_W'(16'sh7fff) : $signed(sum_mag[PCM_W-1:0]);
		end
	end

	mss_ram #(
		.WIDTH(ACC_W),
		.DEPTH(TONE_SLOTS)
	) u_acc_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(t_q),
		.wdata(acc_next),
		.raddr(t_q),
		.rdata(acc_rd)
	);

	mss_div #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc_cur),
		.rate   (rate_q),
		.done   (div_done),
		.idx    (div_idx),
		.acc_mod(div_mod)
	);

	mss_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wr_en),
		.idx    (div_idx),
		.amp    (amp),
		.done   (sine_done),
		.contrib(sine_contrib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			for (int i = 0; i < TONE_SLOTS; i++) begin
				tone_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			if (cfg_index == REG_SAMPLE_RATE) begin
				rate_q <= cfg_data[ACC_W-1:0];
			end else begin
				tone_q[cfg_slot] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vld_q         <= '0;
			t_q           <= '0;
			sum_q         <= '0;
			rerr_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			sample_q      <= '0;
			clipped_q     <= 1'b0;
			range_error_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							vld_q <= '0;
						end
						t_q     <= '0;
						sum_q   <= '0;
						rerr_q  <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (out_of_range) begin
						rerr_q <= 1'b1;
						if (t_q == SLOT_W'(NUM_TONES - 1)) begin
							state_q <= S_DONE;
						end else begin
							t_q <= t_q + SLOT_W'(1);
						end
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						vld_q[t_q] <= 1'b1;
						state_q    <= S_SINE;
					end
				end
				S_SINE: begin
					if (sine_done) begin
						sum_q <= sum_q + SUM_W'(sine_contrib);
						if (t_q == SLOT_W'(NUM_TONES - 1)) begin
							state_q <= S_DONE;
						end else begin
							t_q     <= t_q + SLOT_W'(1);
							state_q <= S_CHECK;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						sample_q      <= sat_sample;
						clipped_q     <= sat_clip;
						range_error_q <= rerr_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign clipped     = clipped_q;
	assign range_error = range_error_q;

endmodule

@@ rtl/mss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mss_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 7
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/mss_div.sv @@
// Bit-serial restoring divider: table index and phase remainder.
`timescale 1ns / 1ps

module mss_div
	import mss_pkg::*;
#(
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  acc_t                       acc,
	input  acc_t                       rate,
	output logic                       done,
	output logic [SINE_TABLE_BITS-1:0] idx,
	output acc_t                       acc_mod
);

	localparam int DW = ACC_W + SINE_TABLE_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]              dvd_q;
	acc_t                       rem_q;
	acc_t                       mod_q;
	logic [SINE_TABLE_BITS-1:0] quo_q;
	logic [CW-1:0]              cnt_q;
	logic                       run_q;
	logic                       done_q;

	logic [ACC_W:0] shl;
	logic [ACC_W:0] trial;
	logic           fits;
	acc_t           nrem;

	always_comb begin
		shl   = {rem_q, dvd_q[DW-1]};
		fits  = shl >= {1'b0, rate};
		trial = shl - {1'b0, rate};
		nrem  = fits ? trial[ACC_W-1:0] : shl[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {acc, {SINE_TABLE_BITS{1'b0}}};
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= nrem;
			quo_q <= {quo_q[SINE_TABLE_BITS-2:0], fits};
			if (cnt_q == CW'(ACC_W - 1)) begin
				mod_q <= nrem;
			end
		end
	end

	assign done    = done_q;
	assign idx     = quo_q;
	assign acc_mod = mod_q;

endmodule

@@ rtl/mss_sine.sv @@
// Sine evaluation and amplitude scaling on one shared multiplier.
`timescale 1ns / 1ps

module mss_sine
	import mss_pkg::*;
#(
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [SINE_TABLE_BITS-1:0]  idx,
	input  amp_t                        amp,
	output logic                        done,
	output logic signed [CONTRIB_W-1:0] contrib
);

	localparam int QB  = SINE_TABLE_BITS - 2;
	localparam int QTR = 1 << QB;

	typedef enum logic [7:0] {
		ST_SQ = 8'b0000_0001,
		ST_H7 = 8'b0000_0010,
		ST_H5 = 8'b0000_0100,
		ST_H3 = 8'b0000_1000,
		ST_H1 = 8'b0001_0000,
		ST_S  = 8'b0010_0000,
		ST_M  = 8'b0100_0000,
		ST_A  = 8'b1000_0000
	} step_t;

	step_t                       step_q;
	logic                        half_q;
	logic                        run_q;
	logic                        done_q;
	logic                        neg_q;
	amp_t                        amp_q;
	amp_t                        mag_q;
	logic [MUL_W-1:0]            x_q;
	logic [MUL_W-1:0]            x2_q;
	logic [MUL_W-1:0]            p_q;
	logic [2*MUL_W-1:0]          prod_q;
	logic signed [CONTRIB_W-1:0] contrib_q;

	logic [QB:0]       rr;
	logic [MUL_W-1:0]  x_in;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [MUL_W-1:0]  prod_hi;
	logic [46:0]       rnd;
	logic [16:0]       mraw;

	always_comb begin
		rr = idx[QB] ? ((QB+1)'(QTR) - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
		x_in    = {rr, {(MUL_W - QB - 1){1'b0}}};
		prod_hi = prod_q[60:30];
		rnd     = prod_q[46:0] + 47'(1 << 29);
		mraw    = rnd[46:30];
	end

	always_comb begin
		unique case (step_q)
			ST_SQ: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_H7: begin
				mul_a = x2_q;
				mul_b = C9;
			end
			ST_H5, ST_H3, ST_H1: begin
				mul_a = x2_q;
				mul_b = p_q;
			end
			ST_S: begin
				mul_a = x_q;
				mul_b = p_q;
			end
			ST_M: begin
				mul_a = p_q;
				mul_b = MUL_W'(MAG_MAX);
			end
			ST_A: begin
				mul_a = MUL_W'(amp_q);
				mul_b = MUL_W'(mag_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_SQ;
			half_q <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= ST_SQ;
				half_q <= 1'b0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				half_q <= !half_q;
				if (half_q) begin
					unique case (step_q)
						ST_SQ:   step_q <= ST_H7;
						ST_H7:   step_q <= ST_H5;
						ST_H5:   step_q <= ST_H3;
						ST_H3:   step_q <= ST_H1;
						ST_H1:   step_q <= ST_S;
						ST_S:    step_q <= ST_M;
						ST_M:    step_q <= ST_A;
						ST_A: begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end
						default: step_q <= ST_SQ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x_in;
			amp_q <= amp;
			neg_q <= idx[QB+1];
		end else if (run_q) begin
			if (!half_q) begin
				prod_q <= mul_a * mul_b;
			end else begin
				case (step_q)
					ST_SQ: x2_q <= prod_hi;
					ST_H7: p_q  <= C7 - prod_hi;
					ST_H5: p_q  <= C5 - prod_hi;
					ST_H3: p_q  <= C3 - prod_hi;
					ST_H1: p_q  <= C1 - prod_hi;
					ST_S:  p_q  <= prod_hi;
					ST_M:  mag_q <= (mraw > 17'(MAG_MAX)) ? MAG_MAX : mraw[AMP_W-1:0];
					ST_A: begin
						contrib_q <= neg_q ? -$signed({1'b0, prod_q[29:0]})
						                   : $signed({1'b0, prod_q[29:0]});
					end
					default: p_q <= p_q;
				endcase
			end
		end
	end

	assign done    = done_q;
	assign contrib = contrib_q;

endmodule
